>>> hw/rtl/coprime_probe_stride_assert.svh
// Assertion macros for the coprime probe stride block.
// Included by modules that check their own logic; expects clk and arst_n in scope.
`ifndef COPRIME_PROBE_STRIDE_ASSERT_SVH
`define COPRIME_PROBE_STRIDE_ASSERT_SVH

// Check a property every clock outside reset.
`define CPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition in one cycle brings a condition in the next.
`define CPS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> hw/rtl/cps_pkg.sv
// Shared constants for the coprime probe stride block.
// No dependencies.
package cps_pkg;

	typedef logic [2:0] cps_state_t;

	localparam cps_state_t ST_IDLE  = 3'd0;
	localparam cps_state_t ST_MOD   = 3'd1; // seed mod (capacity - 1)
	localparam cps_state_t ST_GTEST = 3'd2; // Euclid step decision
	localparam cps_state_t ST_GMOD  = 3'd3; // x mod y for one Euclid step
	localparam cps_state_t ST_FIN   = 3'd4; // publish result word

endpackage

>>> hw/rtl/coprime_probe_stride.sv
// capacity <= 1 skips the search and publishes a stride of 1. Otherwise the seed is
//   reduced mod (capacity - 1) and candidates are tried in turn, each by Euclid steps;
//   one item is in work at a time.
// The remainder unit is a bit-serial restoring divider that takes one dividend
// bit per cycle. done pulses for one cycle with stride.
// Reset (arst_n low, asynchronous) returns to idle and drops done.
module coprime_probe_stride #(
	parameter int CAPACITY_BITS = 16,
	parameter int SEED_BITS     = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [SEED_BITS-1:0]     seed,
	input  logic [CAPACITY_BITS-1:0] capacity,
	output logic                     busy,
	output logic                     done,
	output logic [CAPACITY_BITS-1:0] stride
);
	import cps_pkg::*;
	`include "coprime_probe_stride_assert.svh"

	localparam int CB    = CAPACITY_BITS;
	localparam int DW    = (SEED_BITS > CAPACITY_BITS) ? SEED_BITS : CAPACITY_BITS;
	localparam int CNT_W = $clog2(DW + 1);

	cps_state_t        state_q;
	logic [CB-1:0]     cap_q;     // latched capacity
	logic [CB-1:0]     cand_q;    // current candidate stride
	logic [CB-1:0]     x_q;       // Euclid dividend
	logic [CB-1:0]     y_q;       // Euclid divisor
	logic [CB-1:0]     div_q;     // divisor of the serial remainder unit
	logic [CB-1:0]     rem_q;     // partial remainder
	logic [DW-1:0]     dvd_q;     // dividend shift register, MSB first
	logic [CNT_W-1:0]  cnt_q;     // dividend bits still to shift in
	logic              done_q;
	logic [CB-1:0]     stride_q;

	// One restoring division step: bring in the next dividend bit, subtract if it fits.
	logic [CB:0]   shifted;
	logic [CB:0]   diff;
	logic [CB-1:0] rem_nx;
	logic [CB:0]   cand_inc;
	logic [CB-1:0] cand_nx;

	always_comb begin
		shifted  = {rem_q, dvd_q[DW-1]};
		diff     = shifted - {1'b0, div_q};
		rem_nx   = diff[CB] ? shifted[CB-1:0] : diff[CB-1:0];
		// Step the candidate, wrapping to 1 at the capacity.
		cand_inc = {1'b0, cand_q} + {{CB{1'b0}}, 1'b1};
		cand_nx  = (cand_inc >= {1'b0, cap_q}) ? {{(CB-1){1'b0}}, 1'b1} : cand_inc[CB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (capacity <= {{(CB-1){1'b0}}, 1'b1}) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_MOD;
						end
						cnt_q <= CNT_W'(SEED_BITS);
					end
				end
				ST_MOD: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == {{(CNT_W-1){1'b0}}, 1'b1}) begin
						state_q <= ST_GTEST;
					end
				end
				ST_GTEST: begin
					if (y_q == '0) begin
						if (x_q == {{(CB-1){1'b0}}, 1'b1}) begin
							state_q <= ST_FIN;
						end
					end else begin
						state_q <= ST_GMOD;
						cnt_q   <= CNT_W'(CAPACITY_BITS);
					end
				end
				ST_GMOD: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == {{(CNT_W-1){1'b0}}, 1'b1}) begin
						state_q <= ST_GTEST;
					end
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cap_q  <= capacity;
				cand_q <= {{(CB-1){1'b0}}, 1'b1};
				div_q  <= capacity - {{(CB-1){1'b0}}, 1'b1};
				rem_q  <= '0;
				dvd_q  <= DW'(seed) << (DW - SEED_BITS);
			end
			ST_MOD: begin
				rem_q <= rem_nx;
				dvd_q <= dvd_q << 1;
				if (cnt_q == {{(CNT_W-1){1'b0}}, 1'b1}) begin
					// Start candidate is 1 + seed mod (capacity - 1).
					cand_q <= rem_nx + {{(CB-1){1'b0}}, 1'b1};
					y_q    <= rem_nx + {{(CB-1){1'b0}}, 1'b1};
					x_q    <= cap_q;
				end
			end
			ST_GTEST: begin
				if (y_q == '0) begin
					if (x_q != {{(CB-1){1'b0}}, 1'b1}) begin
						// Not coprime: advance and restart Euclid.
						cand_q <= cand_nx;
						x_q    <= cap_q;
						y_q    <= cand_nx;
					end
				end else begin
					div_q <= y_q;
					rem_q <= '0;
					dvd_q <= DW'(x_q) << (DW - CB);
				end
			end
			ST_GMOD: begin
				rem_q <= rem_nx;
				dvd_q <= dvd_q << 1;
				if (cnt_q == {{(CNT_W-1){1'b0}}, 1'b1}) begin
					x_q <= y_q;
					y_q <= rem_nx;
				end
			end
			ST_FIN: begin
				stride_q <= cand_q;
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign stride = stride_q;

	`CPS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`CPS_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
	`CPS_ASSERT(a_done_nonzero, done |-> (stride != '0), "stride of zero published")
	`CPS_ASSERT(a_rem_bound, ((state_q == ST_MOD) || (state_q == ST_GMOD)) |-> (rem_q < div_q),
		"partial remainder not below divisor")
	`CPS_ASSERT(a_cand_range, (state_q == ST_GTEST) |-> ((cand_q != '0) && (cand_q < cap_q)),
		"candidate stride out of range")

endmodule
